// ===== rtl/bva_pkg.sv =====
`timescale 1ns / 1ps

package bva_pkg;

    // Field widths
    localparam int RAW_W     = 12;
    localparam int CAL_W     = 11;
    localparam int AVG_W     = 15;
    localparam int CNT_OUT_W = 4;
    localparam int MV_W      = 16;

    localparam int DEFAULT_WINDOW_DEPTH = 8;

    localparam logic [CAL_W-1:0] CAL_RESET = 11'd1029;

    // Conversion constants
    localparam int ADC_SCALE_MV   = 3600;
    localparam int ADC_SHIFT      = 12;
    localparam int DIVIDER_TOP    = 1510;
    localparam int DIVIDER_BOTTOM = 510;
    localparam int PERMILLE       = 1000;

    // Intermediate widths: raw*3600 < 2^24, adc_mv <= 3599, adc_mv*1510 < 2^23,
    // div_mv <= 10655, div_mv*2047 < 2^25
    localparam int ADC_PROD_W = RAW_W + 12;
    localparam int ADC_MV_W   = 12;
    localparam int PROD1_W    = 23;
    localparam int DIV_MV_W   = 14;
    localparam int PROD2_W    = 25;
    localparam int DIVISOR_MIN_W = 10;

    // Reciprocals for the constant divisions: (x*M) >> S equals x/d for every
    // x of the product width feeding it (M*d - 2^S stays below 2^(S-width))
    localparam int RECIP_510_W      = 24;
    localparam int RECIP_510_SHIFT  = 32;
    localparam logic [RECIP_510_W-1:0] RECIP_510 = 24'd8421505;
    localparam int RECIP_1000_W     = 26;
    localparam int RECIP_1000_SHIFT = 35;
    localparam logic [RECIP_1000_W-1:0] RECIP_1000 = 26'd34359739;
    localparam int SCALE1_W = PROD1_W + RECIP_510_W;
    localparam int SCALE2_W = PROD2_W + RECIP_1000_W;

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CALIBRATION = 1'b0;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'b01,
        OP_FAIL   = 2'b10
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [RAW_W-1:0] raw;
    } item_t;

endpackage

// ===== rtl/bva_if.sv =====
`timescale 1ns / 1ps

interface bva_in_if import bva_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_sample;
    logic             conversion_failed;

    modport source (output valid, raw_sample, conversion_failed, input ready);
    modport sink   (input valid, raw_sample, conversion_failed, output ready);
endinterface

interface bva_out_if import bva_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [AVG_W-1:0]     average_mv;
    logic [CNT_OUT_W-1:0] samples_averaged;

    modport source (output valid, average_mv, samples_averaged, input ready);
    modport sink   (input valid, average_mv, samples_averaged, output ready);
endinterface

// ===== rtl/battery_voltage_averager.sv =====
`timescale 1ns / 1ps

// Battery voltage averager: each transfer on sample_in carries one 12-bit ADC
// reading, which is scaled to millivolts (raw*3600/4096, *1510/510 for the
// divider, *calibration/1000, each step truncating), stored in a ring of
// WINDOW_DEPTH entries, and answered on result_out with the truncated mean of
// the entries the ring holds together with their count. A failed conversion
// returns zero for both fields and leaves the ring untouched. A valid reading
// passes through five scaling steps, where /510 and /1000 are reciprocal
// multiplies, then the bit-serial divider that forms the mean; a failed one
// goes straight to the result. A two-entry queue takes readings while the back
// end works, and the result register holds a finished result while the next
// reading is processed. The calibration register sits at byte address 0 of
// the APB port and resets to 1029.
module battery_voltage_averager import bva_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bva_in_if.sink                sample_in,
    bva_out_if.source             result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAL_W-1:0]     cal_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    item_t                head;
    logic                 head_valid;
    logic                 pop;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_CALIBRATION) ? APB_DATA_W'(cal_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= CAL_RESET;
        end
        else if (cfg_write && (reg_idx == REG_CALIBRATION))
        begin
            cal_reg <= pwdata[CAL_W-1:0];
        end
    end

    bva_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    bva_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cal        (cal_reg),
        .result_out (result_out)
    );

endmodule

// ===== rtl/bva_front.sv =====
`timescale 1ns / 1ps

module bva_front import bva_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bva_in_if.sink     sample_in,
    output item_t      head,
    output logic       head_valid,
    input  logic       pop
);

    item_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               do_pop;
    item_t              new_item;

    assign sample_in.ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign push            = sample_in.valid && sample_in.ready;
    assign head_valid      = (count_reg != '0);
    assign do_pop          = pop && head_valid;
    assign head            = q_mem[rd_ptr_reg];

    // Classify on entry so the back end only dispatches on the op code
    always_comb
    begin
        new_item.op  = sample_in.conversion_failed ? OP_FAIL : OP_SAMPLE;
        new_item.raw = sample_in.raw_sample;
    end

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/bva_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module bva_div import bva_pkg::*;
#(
    parameter int DVD_W = PROD2_W,
    parameter int DVS_W = DIVISOR_MIN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int ITER_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            iter_next = ITER_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            rem_next  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

endmodule

// ===== rtl/bva_back.sv =====
`timescale 1ns / 1ps

module bva_back import bva_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            head,
    input  logic             head_valid,
    output logic             pop,
    input  logic [CAL_W-1:0] cal,
    bva_out_if.source        result_out
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = MV_W + CNT_W;
    localparam int DVD_W = SUM_W;
    localparam int DVS_W = CNT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL1  = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_MUL2  = 8'b0000_1000,
        S_DIV2  = 8'b0001_0000,
        S_STORE = 8'b0010_0000,
        S_DIV3  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic                  full_reg, full_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADC_MV_W-1:0]   adc_reg;
    logic [PROD1_W-1:0]    prod1_reg;
    logic [DIV_MV_W-1:0]   div_mv_reg;
    logic [PROD2_W-1:0]    prod2_reg;
    logic [MV_W-1:0]       bat_reg;
    logic [MV_W-1:0]       old_reg;
    logic [AVG_W-1:0]      res_avg_reg;
    logic [CNT_OUT_W-1:0]  res_cnt_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]      out_avg_reg;
    logic [CNT_OUT_W-1:0]  out_cnt_reg;
    logic [MV_W-1:0]       ring_mem [WINDOW_DEPTH];

    logic [ADC_PROD_W-1:0] adc_prod;
    logic [PROD1_W-1:0]    prod1;
    logic [PROD2_W-1:0]    prod2;
    logic [SCALE1_W-1:0]   scale1;
    logic [SCALE2_W-1:0]   scale2;
    logic                  wrap;
    logic [SUM_W-1:0]      old_term;
    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quotient;
    logic                  out_load;

    assign adc_prod = ADC_PROD_W'(head.raw) * ADC_PROD_W'(ADC_SCALE_MV);
    assign prod1    = PROD1_W'(adc_reg) * PROD1_W'(DIVIDER_TOP);
    assign prod2    = PROD2_W'(div_mv_reg) * PROD2_W'(cal);

    // /510 and /1000 by reciprocal multiplication, one step per state
    assign scale1   = SCALE1_W'(prod1_reg) * SCALE1_W'(RECIP_510);
    assign scale2   = SCALE2_W'(prod2_reg) * SCALE2_W'(RECIP_1000);

    // Running sum: the mean always covers exactly the entries held in the ring,
    // so the overwritten entry only drops out once the ring has wrapped.
    assign wrap       = (wp_reg == PTR_W'(WINDOW_DEPTH - 1));
    assign wp_next    = wrap ? '0 : wp_reg + 1'b1;
    assign full_next  = full_reg || wrap;
    assign old_term   = full_reg ? SUM_W'(old_reg) : '0;
    assign sum_next   = sum_reg + SUM_W'(bat_reg) - old_term;
    assign count_next = full_next ? CNT_W'(WINDOW_DEPTH) : CNT_W'(wp_reg) + 1'b1;

    assign pop = (state_reg == S_IDLE) && head_valid;

    assign div_start    = (state_reg == S_STORE);
    assign div_dividend = DVD_W'(sum_next);
    assign div_divisor  = DVS_W'(count_next);

    bva_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head.op == OP_FAIL) ? S_DONE : S_MUL1;
                end
            end
            S_MUL1:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                state_next = S_STORE;
            end
            S_STORE:
            begin
                state_next = S_DIV3;
            end
            S_DIV3:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_STORE)
            begin
                wp_reg   <= wp_next;
                full_reg <= full_next;
                sum_reg  <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            adc_reg     <= adc_prod[ADC_SHIFT +: ADC_MV_W];
            res_avg_reg <= '0;
            res_cnt_reg <= '0;
        end
        if (state_reg == S_MUL1)
        begin
            prod1_reg <= prod1;
        end
        if (state_reg == S_DIV1)
        begin
            div_mv_reg <= scale1[RECIP_510_SHIFT +: DIV_MV_W];
        end
        if (state_reg == S_MUL2)
        begin
            prod2_reg <= prod2;
        end
        if (state_reg == S_DIV2)
        begin
            bat_reg <= scale2[RECIP_1000_SHIFT +: MV_W];
        end
        if (state_reg == S_STORE)
        begin
            count_reg <= count_next;
        end
        if ((state_reg == S_DIV3) && div_done)
        begin
            res_avg_reg <= div_quotient[AVG_W-1:0];
            res_cnt_reg <= CNT_OUT_W'(count_reg);
        end
        if (out_load)
        begin
            out_avg_reg <= res_avg_reg;
            out_cnt_reg <= res_cnt_reg;
        end
    end

    // Sample ring: entry under the write pointer is read ahead, then replaced
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1)
        begin
            old_reg <= ring_mem[wp_reg];
        end
        if (state_reg == S_STORE)
        begin
            ring_mem[wp_reg] <= bat_reg;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.average_mv       = out_avg_reg;
    assign result_out.samples_averaged = out_cnt_reg;

endmodule

// ===== rtl/bva_checker.sv =====
`timescale 1ns / 1ps

module bva_checker import bva_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [AVG_W-1:0]     average_mv,
    input logic [CNT_OUT_W-1:0] samples_averaged
);

    logic [2:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A result only ever answers an accepted reading
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 3'd0))
        else $error("result presented with no reading outstanding");

    // Queue plus back end plus result register bound what can be in flight
    a_bounded_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(MAX_OUTSTANDING))
        else $error("more readings in flight than the block can hold");

    // Empty mean only comes from a failed conversion
    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (samples_averaged == '0)) |-> (average_mv == '0))
        else $error("zero sample count with nonzero average");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(average_mv) && $stable(samples_averaged)))
        else $error("result changed or dropped while stalled");

endmodule

bind battery_voltage_averager bva_checker u_bva_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sample_in.valid),
    .in_ready         (sample_in.ready),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .average_mv       (result_out.average_mv),
    .samples_averaged (result_out.samples_averaged)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bva_pkg::*;

    localparam int WINDOW     = DEFAULT_WINDOW_DEPTH;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 165;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [APB_ADDR_W-1:0] CAL_ADDR      = {REG_CALIBRATION, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

    typedef struct {
        logic [RAW_W-1:0] raw;
        logic             failed;
    } reading_t;

    typedef struct {
        logic [AVG_W-1:0]     average_mv;
        logic [CNT_OUT_W-1:0] samples_averaged;
    } average_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bva_in_if  sample_bus ();
    bva_out_if result_bus ();

    battery_voltage_averager i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_bus),
        .result_out (result_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 clk = ~clk;

    // readings waiting to be sent, averages waiting to come back
    reading_t readings_pending[$];
    average_t averages_due[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned failures       = 0;
    int unsigned quiet_cycles   = 0;

    // mirror of the block's state
    logic [CAL_W-1:0] cal_setting = CAL_RESET;
    logic [MV_W-1:0]  mv_ring[WINDOW];
    int unsigned      ring_pos  = 0;
    bit               ring_full = 0;

    function automatic void predict_average(input logic [RAW_W-1:0] raw, input logic failed);
        average_t    res;
        int unsigned adc_mv;
        int unsigned div_mv;
        int unsigned total;
        int unsigned n;
        if (failed)
        begin
            res.average_mv       = '0;
            res.samples_averaged = '0;
        end
        else
        begin
            adc_mv = (int'(raw) * ADC_SCALE_MV) >> ADC_SHIFT;
            div_mv = adc_mv * DIVIDER_TOP / DIVIDER_BOTTOM;
            mv_ring[ring_pos] = MV_W'(div_mv * int'(cal_setting) / PERMILLE);
            if (ring_pos == WINDOW - 1)
            begin
                ring_pos  = 0;
                ring_full = 1;
            end
            else
                ring_pos++;
            n = ring_full ? WINDOW : ring_pos;
            total = 0;
            for (int i = 0; i < n; i++)
                total += mv_ring[i];
            res.average_mv       = AVG_W'(total / n);
            res.samples_averaged = CNT_OUT_W'(n);
        end
        averages_due.push_back(res);
    endfunction

    // sender: holds each reading until its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bus.valid             <= 1'b0;
            sample_bus.raw_sample        <= '0;
            sample_bus.conversion_failed <= 1'b0;
        end
        else
        begin
            if (sample_bus.valid && sample_bus.ready)
                predict_average(sample_bus.raw_sample, sample_bus.conversion_failed);
            if (!sample_bus.valid || sample_bus.ready)
            begin
                if (readings_pending.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    reading_t r;
                    r = readings_pending.pop_front();
                    sample_bus.valid             <= 1'b1;
                    sample_bus.raw_sample        <= r.raw;
                    sample_bus.conversion_failed <= r.failed;
                end
                else
                    sample_bus.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (averages_due.size() == 0)
                begin
                    $error("unexpected result: average_mv %0d samples_averaged %0d",
                           result_bus.average_mv, result_bus.samples_averaged);
                    failures++;
                end
                else
                begin
                    average_t want;
                    want = averages_due.pop_front();
                    if (result_bus.average_mv !== want.average_mv)
                    begin
                        $error("average_mv: expected %0d, got %0d",
                               want.average_mv, result_bus.average_mv);
                        failures++;
                    end
                    if (result_bus.samples_averaged !== want.samples_averaged)
                    begin
                        $error("samples_averaged: expected %0d, got %0d",
                               want.samples_averaged, result_bus.samples_averaged);
                        failures++;
                    end
                end
            end
            result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog: counts cycles without a transfer while work is outstanding
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                || (readings_pending.size() == 0 && !sample_bus.valid
                    && averages_due.size() == 0))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (readings_pending.size() > 0 || sample_bus.valid || averages_due.size() > 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAL_ADDR)
            cal_setting = data[CAL_W-1:0];
    endtask

    task automatic check_calibration();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAL_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[CAL_W-1:0] !== cal_setting)
        begin
            $error("calibration_permille: expected %0d, got %0d", cal_setting, prdata[CAL_W-1:0]);
            failures++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_calibration(input logic [APB_DATA_W-1:0] data);
        apb_write(CAL_ADDR, data);
        check_calibration();
    endtask

    function automatic void queue_reading(input int raw, input bit failed);
        reading_t r;
        r.raw    = RAW_W'(raw);
        r.failed = failed;
        readings_pending.push_back(r);
    endfunction

    function automatic void queue_random_readings(input int count);
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(15);
            if (pick == 0)
                queue_reading(0, $urandom_range(9) == 0);
            else if (pick == 1)
                queue_reading((1 << RAW_W) - 1, $urandom_range(9) == 0);
            else
                queue_reading($urandom_range((1 << RAW_W) - 1), $urandom_range(9) == 0);
        end
    endfunction

    initial
    begin
        logic [APB_DATA_W-1:0] phase_cal[8];
        int unsigned           idle_plan[4][2];

        idle_plan = '{'{0, 0}, '{82, 0}, '{0, 82}, '{36, 36}};
        phase_cal = '{32'd0, 32'd2000, 32'd1, 32'($urandom_range(2047)),
                      32'hFFFF_F800 | 32'd1029, 32'($urandom_range(2047)), 32'd2047, 32'd1000};

        rst_n                        = 1'b0;
        psel                         = 1'b0;
        penable                      = 1'b0;
        pwrite                       = 1'b0;
        paddr                        = '0;
        pwdata                       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of the calibration register
        check_calibration();

        // failure on an empty ring, extremes, wrap of the ring with a failure inside
        queue_reading(0, 1);
        queue_reading(0, 0);
        queue_reading(4095, 0);
        queue_reading(4095, 1);
        queue_reading(1, 0);
        queue_reading(2048, 0);
        queue_reading(4095, 0);
        queue_reading(4095, 0);
        queue_reading(0, 1);
        queue_reading(4095, 0);
        queue_reading(2730, 0);
        queue_reading(0, 0);
        queue_reading(1365, 0);
        queue_reading(3000, 0);
        wait_drained();

        // largest gain: ring full of full-scale readings gives the top average
        set_calibration(32'd2047);
        for (int i = 0; i < WINDOW + 1; i++)
            queue_reading(4095, 0);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            src_idle_pct   = idle_plan[p % 4][0];
            sink_stall_pct = idle_plan[p % 4][1];
            set_calibration(phase_cal[p]);
            if (p == 2)
            begin
                // write to an unmapped index must leave calibration alone
                apb_write(UNMAPPED_ADDR, $urandom);
                check_calibration();
            end
            queue_random_readings(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
